FILE: hw/rtl/adlp_pkg.sv
package adlp_pkg;

	localparam int CHAR_W    = 8;
	localparam int FIELD_W   = 4;
	localparam int MS_W      = 26;
	localparam int TVAL_W    = MS_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int RES_MAX   = 3;
	localparam int PUSH_W    = 2;
	localparam int FIFO_DEPTH = 8;
	localparam int PREFIX_LEN = 9;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [MS_W-1:0]    ms_t;
	typedef logic [TVAL_W-1:0]  tval_t;

	localparam tval_t TIME_INVALID = {1'b1, {MS_W{1'b0}}};

	typedef enum logic [1:0] {
		ST_TEXT    = 2'd0,
		ST_NOT_DLG = 2'd1,
		ST_DROPPED = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_FIELD = 2'd0,
		REG_END_FIELD   = 2'd1,
		REG_TEXT_FIELD  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic    has_char;
		char_t   text_char;
		logic    segment_end;
		logic    line_done;
		status_t line_status;
		ms_t     start_ms;
		ms_t     end_ms;
	} result_t;

	typedef struct packed {
		logic [PUSH_W-1:0]         cnt;
		result_t [RES_MAX-1:0]     res;
	} push_t;

	function automatic char_t prefix_char(logic [3:0] idx);
		char_t c;
		case (idx)
			4'd0: c = "D";
			4'd1: c = "i";
			4'd2: c = "a";
			4'd3: c = "l";
			4'd4: c = "o";
			4'd5: c = "g";
			4'd6: c = "u";
			4'd7: c = "e";
			4'd8: c = ":";
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic char_t part_sep(logic [1:0] idx);
		char_t c;
		case (idx)
			2'd0: c = ":";
			2'd1: c = ":";
			2'd2: c = ".";
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic ms_t part_ms(logic [1:0] idx, logic [6:0] pv);
		ms_t v;
		case (idx)
			2'd0: v = ms_t'(pv) * ms_t'(3600000);
			2'd1: v = ms_t'(pv) * ms_t'(60000);
			2'd2: v = ms_t'(pv) * ms_t'(1000);
			default: v = ms_t'(pv) * ms_t'(10);
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/adlp_char_if.sv
interface adlp_char_if import adlp_pkg::*; ();
	logic  valid;
	logic  ready;
	char_t char_in;
	logic  line_last;

	modport source (output valid, output char_in, output line_last, input ready);
	modport sink (input valid, input char_in, input line_last, output ready);
endinterface

FILE: hw/rtl/adlp_cfg_if.sv
interface adlp_cfg_if import adlp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	field_t               data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/adlp_res_if.sv
interface adlp_res_if import adlp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       has_char;
	char_t      text_char;
	logic       segment_end;
	logic       line_done;
	logic [1:0] line_status;
	ms_t        start_ms;
	ms_t        end_ms;

	modport source (output valid, output has_char, output text_char, output segment_end,
		output line_done, output line_status, output start_ms, output end_ms, input ready);
	modport sink (input valid, input has_char, input text_char, input segment_end,
		input line_done, input line_status, input start_ms, input end_ms, output ready);
endinterface

FILE: hw/rtl/adlp_core.sv
module adlp_core import adlp_pkg::*; #(
	parameter int LINE_LIMIT = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	adlp_char_if.sink    chars,
	adlp_cfg_if.sink     cfg,
	input  logic         room,
	output push_t        push
);

	localparam int CNT_W = $clog2(LINE_LIMIT);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_LIMIT - 1);

	typedef enum logic [1:0] {FK_OTHER, FK_START, FK_END, FK_TEXT} fkind_t;
	typedef enum logic [1:0] {TM_NONE, TM_TEXT, TM_DROP} tmode_t;

	logic  v_s1, last_s1, fire;
	char_t char_s1;

	field_t cfg_start_q, cfg_end_q, cfg_text_q;

	logic [3:0]       prefix_q, prefix_d;
	logic             dlg_q, dlg_d;
	logic [3:0]       comma_q, comma_d;
	logic             skip_q, skip_d;
	logic [2:0]       tpart_q, tpart_d;
	logic [1:0]       dcnt_q, dcnt_d;
	logic [6:0]       pval_q, pval_d;
	ms_t              acc_q, acc_d;
	tval_t            start_q, start_d, end_q, end_d;
	logic             tag_q, tag_d;
	logic             bslash_q, bslash_d;
	logic [CNT_W-1:0] ccnt_q, ccnt_d;
	fkind_t           fk_q, fk_d;
	tmode_t           tm_q, tm_d;

	logic             keep, isdig, st_en;
	logic [3:0]       dig;
	logic [1:0]       most;
	logic [6:0]       pv_new;
	tval_t            st_val;
	logic [PUSH_W-1:0] n;

	assign fire        = v_s1 && room;
	assign chars.ready = !v_s1 || fire;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
			last_s1 <= chars.line_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_start_q <= field_t'(1);
			cfg_end_q   <= field_t'(2);
			cfg_text_q  <= field_t'(9);
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_START_FIELD: cfg_start_q <= cfg.data;
				REG_END_FIELD:   cfg_end_q   <= cfg.data;
				REG_TEXT_FIELD:  cfg_text_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	function automatic result_t mk(logic hc, char_t ch, logic se, logic ld, status_t st,
		tval_t sv, tval_t ev);
		result_t r;
		r.has_char    = hc;
		r.text_char   = ch;
		r.segment_end = se;
		r.line_done   = ld;
		r.line_status = st;
		r.start_ms    = (st == ST_TEXT) ? sv[MS_W-1:0] : '0;
		r.end_ms      = (st == ST_TEXT) ? ev[MS_W-1:0] : '0;
		return r;
	endfunction

	function automatic logic time_ok(tval_t v);
		return !v[MS_W] && (v != '0);
	endfunction

	always_comb begin
		prefix_d = prefix_q;
		dlg_d    = dlg_q;
		comma_d  = comma_q;
		skip_d   = skip_q;
		tpart_d  = tpart_q;
		dcnt_d   = dcnt_q;
		pval_d   = pval_q;
		acc_d    = acc_q;
		start_d  = start_q;
		end_d    = end_q;
		tag_d    = tag_q;
		bslash_d = bslash_q;
		ccnt_d   = ccnt_q;
		fk_d     = fk_q;
		tm_d     = tm_q;
		push     = '0;
		n        = '0;
		st_en    = 1'b0;
		st_val   = TIME_INVALID;
		isdig    = (char_s1 >= "0") && (char_s1 <= "9");
		dig      = 4'(char_s1 - "0");
		most     = (tpart_q == 3'd0) ? 2'd1 : 2'd2;
		pv_new   = 7'(pval_q * 7'd10 + 7'(dig));
		keep     = fire && (char_s1 != '0) && (ccnt_q < CNT_MAX);

		if (keep) begin
			ccnt_d = ccnt_q + 1'b1;
			if (prefix_q < 4'(PREFIX_LEN)) begin
				if (char_s1 == prefix_char(prefix_q)) begin
					prefix_d = prefix_q + 1'b1;
					if (prefix_q == 4'(PREFIX_LEN - 1)) dlg_d = 1'b1;
				end else begin
					prefix_d = 4'hF;
				end
			end else if (dlg_q && !(skip_q && char_s1 == " ")) begin
				skip_d = 1'b0;
				if (tm_q == TM_TEXT) begin
					if (tag_q) begin
						if (char_s1 == "}") tag_d = 1'b0;
					end else if (char_s1 == "{") begin
						tag_d = 1'b1;
					end else if (bslash_q) begin
						if (char_s1 == "N" || char_s1 == "n" || char_s1 == "h") begin
							bslash_d = 1'b0;
							push.res[n] = mk(1'b0, '0, 1'b1, 1'b0, ST_TEXT, start_q, end_q);
							n = n + 1'b1;
						end else begin
							push.res[n] = mk(1'b1, "\\", 1'b0, 1'b0, ST_TEXT, start_q, end_q);
							n = n + 1'b1;
							if (char_s1 != "\\") begin
								bslash_d = 1'b0;
								push.res[n] = mk(1'b1, char_s1, 1'b0, 1'b0, ST_TEXT, start_q, end_q);
								n = n + 1'b1;
							end
						end
					end else if (char_s1 == "\\") begin
						bslash_d = 1'b1;
					end else begin
						push.res[n] = mk(1'b1, char_s1, 1'b0, 1'b0, ST_TEXT, start_q, end_q);
						n = n + 1'b1;
					end
				end else if (tm_q == TM_NONE) begin
					if (char_s1 == ",") begin
						if (fk_q == FK_START || fk_q == FK_END) begin
							if (tpart_q == 3'd3 && dcnt_q != '0) begin
								acc_d   = acc_q + part_ms(2'd3, pval_q);
								tpart_d = 3'd4;
								st_en   = 1'b1;
								st_val  = {1'b0, acc_d};
							end else if (tpart_q < 3'd4) begin
								tpart_d = 3'd5;
								st_en   = 1'b1;
							end
						end
						if (st_en && fk_q == FK_START) start_d = st_val;
						else if (st_en && fk_q == FK_END) end_d = st_val;
						if (comma_q < 4'hF) begin
							comma_d = comma_q + 1'b1;
							fk_d = FK_OTHER;
							if (comma_d == cfg_start_q) begin
								fk_d = FK_START;
							end else if (comma_d == cfg_end_q) begin
								fk_d = FK_END;
							end else if (comma_d == cfg_text_q) begin
								fk_d = FK_TEXT;
								tm_d = (time_ok(start_d) && time_ok(end_d)) ? TM_TEXT : TM_DROP;
							end
							tpart_d = '0;
							dcnt_d  = '0;
							pval_d  = '0;
							acc_d   = '0;
						end else begin
							fk_d = FK_OTHER;
						end
						skip_d = 1'b1;
					end else if ((fk_q == FK_START || fk_q == FK_END) && tpart_q < 3'd4) begin
						if (isdig) begin
							if (dcnt_q >= most) begin
								tpart_d = 3'd5;
								st_en   = 1'b1;
							end else begin
								pval_d = pv_new;
								dcnt_d = dcnt_q + 1'b1;
								if (tpart_q == 3'd3 && dcnt_q == 2'd1) begin
									acc_d   = acc_q + ms_t'(pval_q) * ms_t'(100)
										+ ms_t'(dig) * ms_t'(10);
									tpart_d = 3'd4;
									st_en   = 1'b1;
									st_val  = {1'b0, acc_d};
								end
							end
						end else if (tpart_q == 3'd3) begin
							st_en = 1'b1;
							if (dcnt_q != '0) begin
								acc_d   = acc_q + part_ms(2'd3, pval_q);
								tpart_d = 3'd4;
								st_val  = {1'b0, acc_d};
							end else begin
								tpart_d = 3'd5;
							end
						end else if (char_s1 == part_sep(tpart_q[1:0]) && dcnt_q != '0) begin
							acc_d   = acc_q + part_ms(tpart_q[1:0], pval_q);
							tpart_d = tpart_q + 1'b1;
							dcnt_d  = '0;
							pval_d  = '0;
						end else begin
							tpart_d = 3'd5;
							st_en   = 1'b1;
						end
						if (st_en && fk_q == FK_START) start_d = st_val;
						else if (st_en && fk_q == FK_END) end_d = st_val;
					end
				end
			end
		end

		if (fire && last_s1) begin
			if (dlg_d && tm_d == TM_TEXT) begin
				if (bslash_d) begin
					push.res[n] = mk(1'b1, "\\", 1'b0, 1'b0, ST_TEXT, start_d, end_d);
					n = n + 1'b1;
				end
				push.res[n] = mk(1'b0, '0, 1'b1, 1'b1, ST_TEXT, start_d, end_d);
				n = n + 1'b1;
			end else if (dlg_d) begin
				push.res[n] = mk(1'b0, '0, 1'b0, 1'b1, ST_DROPPED, start_d, end_d);
				n = n + 1'b1;
			end else begin
				push.res[n] = mk(1'b0, '0, 1'b0, 1'b1, ST_NOT_DLG, start_d, end_d);
				n = n + 1'b1;
			end
			prefix_d = '0;
			dlg_d    = 1'b0;
			comma_d  = '0;
			skip_d   = 1'b0;
			tpart_d  = '0;
			dcnt_d   = '0;
			pval_d   = '0;
			acc_d    = '0;
			start_d  = TIME_INVALID;
			end_d    = TIME_INVALID;
			tag_d    = 1'b0;
			bslash_d = 1'b0;
			ccnt_d   = '0;
			fk_d     = FK_OTHER;
			tm_d     = TM_NONE;
		end
		push.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			dlg_q    <= 1'b0;
			comma_q  <= '0;
			skip_q   <= 1'b0;
			tpart_q  <= '0;
			dcnt_q   <= '0;
			pval_q   <= '0;
			acc_q    <= '0;
			start_q  <= TIME_INVALID;
			end_q    <= TIME_INVALID;
			tag_q    <= 1'b0;
			bslash_q <= 1'b0;
			ccnt_q   <= '0;
			fk_q     <= FK_OTHER;
			tm_q     <= TM_NONE;
		end else begin
			prefix_q <= prefix_d;
			dlg_q    <= dlg_d;
			comma_q  <= comma_d;
			skip_q   <= skip_d;
			tpart_q  <= tpart_d;
			dcnt_q   <= dcnt_d;
			pval_q   <= pval_d;
			acc_q    <= acc_d;
			start_q  <= start_d;
			end_q    <= end_d;
			tag_q    <= tag_d;
			bslash_q <= bslash_d;
			ccnt_q   <= ccnt_d;
			fk_q     <= fk_d;
			tm_q     <= tm_d;
		end
	end

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |-> push.cnt != '0)
		else $error("line end produced no result");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> prefix_q == '0 && comma_q == '0 && tm_q == TM_NONE && !tag_q)
		else $error("line state not cleared after line end");

	a_text_needs_dlg: assert property (@(posedge clk) disable iff (!arst_n)
		tm_q != TM_NONE |-> dlg_q)
		else $error("text field reached on a non-dialogue line");

endmodule

FILE: hw/rtl/adlp_fifo.sv
module adlp_fifo import adlp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  push_t        push,
	output logic         room,
	adlp_res_if.source   results
);

	localparam int AW = $clog2(FIFO_DEPTH);

	result_t       mem_q [FIFO_DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   cnt_q;
	logic          pop;
	result_t       head;

	assign room          = cnt_q <= (AW+1)'(FIFO_DEPTH - RES_MAX);
	assign results.valid = cnt_q != '0;
	assign pop           = results.valid && results.ready;
	assign head          = mem_q[rptr_q];

	assign results.has_char    = head.has_char;
	assign results.text_char   = head.text_char;
	assign results.segment_end = head.segment_end;
	assign results.line_done   = head.line_done;
	assign results.line_status = head.line_status;
	assign results.start_ms    = head.start_ms;
	assign results.end_ms      = head.end_ms;

	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (PUSH_W'(i) < push.cnt) mem_q[wptr_q + AW'(i)] <= push.res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + AW'(push.cnt);
			rptr_q <= rptr_q + AW'(pop);
			cnt_q  <= cnt_q + (AW+1)'(push.cnt) - (AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != '0 |-> cnt_q + (AW+1)'(push.cnt) <= (AW+1)'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(FIFO_DEPTH))
		else $error("result queue count out of range");

endmodule

FILE: hw/rtl/ass_dialogue_line_parser.sv
// Streaming subtitle line parser: takes one byte of a "Dialogue:" line per cycle and returns
// kept text characters, segment marks and one closing status word per line; words of a kept
// line carry its start and end times in milliseconds, other words zero. A byte is held in the
// input register, where it is parsed, and its result words (zero to three) go into an eight-word
// result queue; the byte input takes a new byte every cycle while the queue has room for three
// more words, so one byte per cycle is sustained if the output drains on average one word per byte.
// Configuration writes are taken at any cycle and should be issued only between lines.
module ass_dialogue_line_parser import adlp_pkg::*; #(
	parameter int LINE_LIMIT = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	adlp_cfg_if.sink     cfg,
	adlp_char_if.sink    chars,
	adlp_res_if.source   results
);

	push_t push;
	logic  room;

	adlp_core #(
		.LINE_LIMIT (LINE_LIMIT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.cfg    (cfg),
		.room   (room),
		.push   (push)
	);

	adlp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.results (results)
	);

endmodule
